/* rtl/jsu_pkg.sv */
// Shared types, constants and the UTF-8 encoder for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

  localparam int ResMax = 6;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChU = 8'h75;
  localparam logic [7:0] ChB = 8'h62;
  localparam logic [7:0] ChF = 8'h66;
  localparam logic [7:0] ChN = 8'h6E;
  localparam logic [7:0] ChR = 8'h72;
  localparam logic [7:0] ChT = 8'h74;
  localparam logic [7:0] ChSp = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChFf = 8'h0C;
  localparam logic [7:0] ChBs = 8'h08;

  localparam logic [15:0] SurHiMin = 16'hD800;
  localparam logic [15:0] SurHiMax = 16'hDBFF;
  localparam logic [15:0] SurLoMin = 16'hDC00;
  localparam logic [15:0] SurLoMax = 16'hDFFF;
  localparam logic [20:0] PairBase = 21'h10000;
  localparam logic [20:0] Utf8Lim1 = 21'h80;
  localparam logic [20:0] Utf8Lim2 = 21'h800;
  localparam logic [20:0] Utf8Lim3 = 21'h10000;
  localparam logic [7:0] Lead2 = 8'hC0;
  localparam logic [7:0] Lead3 = 8'hE0;
  localparam logic [7:0] Lead4 = 8'hF0;
  localparam logic [7:0] ContMark = 8'h80;

  localparam logic [2:0] ErrNone = 3'd0;
  localparam logic [2:0] ErrStart = 3'd1;
  localparam logic [2:0] ErrUnterm = 3'd2;
  localparam logic [2:0] ErrEndEsc = 3'd3;
  localparam logic [2:0] ErrEscape = 3'd4;
  localparam logic [2:0] ErrHex = 3'd5;
  localparam logic [2:0] ErrShortU = 3'd6;

  typedef enum logic [6:0] {
    M_WAIT     = 7'b0000001,
    M_BODY     = 7'b0000010,
    M_ESC      = 7'b0000100,
    M_HEX      = 7'b0001000,
    M_HIGH     = 7'b0010000,
    M_HIGH_ESC = 7'b0100000,
    M_LOW_HEX  = 7'b1000000
  } mode_t;

  // acc holds up to three hex digits; pend is the low ten bits of a high surrogate
  typedef struct packed {
    mode_t       mode;
    logic [11:0] acc;
    logic [9:0]  pend;
    logic [2:0]  cnt;
  } st_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [2:0] error_code;
  } res_t;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } enc_t;

  localparam res_t ZeroRes = '0;
  localparam st_t ClearSt = '{mode: M_WAIT, acc: 12'd0, pend: 10'd0, cnt: 3'd0};

  function automatic res_t byte_res(input logic [7:0] b);
    res_t r;
    r = '0;
    r.out_byte = b;
    r.byte_valid = 1'b1;
    return r;
  endfunction

  function automatic res_t err_res(input logic [2:0] code);
    res_t r;
    r = '0;
    r.error_code = code;
    return r;
  endfunction

  function automatic res_t done_res();
    res_t r;
    r = '0;
    r.string_done = 1'b1;
    return r;
  endfunction

  function automatic enc_t utf8_enc(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < Utf8Lim1) begin
      e.n = 3'd1;
      e.b[0] = cp[7:0];
    end else if (cp < Utf8Lim2) begin
      e.n = 3'd2;
      e.b[0] = Lead2 | {3'b0, cp[10:6]};
      e.b[1] = ContMark | {2'b0, cp[5:0]};
    end else if (cp < Utf8Lim3) begin
      e.n = 3'd3;
      e.b[0] = Lead3 | {4'b0, cp[15:12]};
      e.b[1] = ContMark | {2'b0, cp[11:6]};
      e.b[2] = ContMark | {2'b0, cp[5:0]};
    end else begin
      e.n = 3'd4;
      e.b[0] = Lead4 | {5'b0, cp[20:18]};
      e.b[1] = ContMark | {2'b0, cp[17:12]};
      e.b[2] = ContMark | {2'b0, cp[11:6]};
      e.b[3] = ContMark | {2'b0, cp[5:0]};
    end
    return e;
  endfunction

endpackage

/* rtl/json_string_unescape_utf8.sv */
// Top level of the JSON string unescaper: parser state, decode and result register.
//
//   channel  | handshake              | word
//   ---------+------------------------+-------------------------------------------------
//   text     | text_valid, text_stall | ch, end_flag
//   result   | res_valid, res_stall   | out_byte, byte_valid, string_done, error_code, last
//
// A text word is decoded in the cycle it is taken; its 0 to 6 result words leave the
// result register one per unstalled cycle starting the next cycle. A new text word is taken
// whenever the result register is empty or its final word leaves in that cycle, so words
// with at most one result stream at one per unstalled cycle. Synchronous reset returns
// the parser to waiting for the opening quote and empties the result register.
`timescale 1ns / 1ps

module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  logic [7:0] ch,
  input  logic       end_flag,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       string_done,
  output logic [2:0] error_code,
  output logic       last
);
  import jsu_pkg::*;

  st_t               st;
  st_t               st_next;
  logic [2:0]        dec_n;
  res_t [ResMax-1:0] dec_list;
  res_t              head;
  logic              ready;
  logic              accept;

  assign text_stall = rst || !ready;
  assign accept = text_valid && !text_stall;

  jsu_decode u_decode (
    .st       (st),
    .ch       (ch),
    .end_flag (end_flag),
    .st_next  (st_next),
    .res_n    (dec_n),
    .res_list (dec_list)
  );

  jsu_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .load_n    (dec_n),
    .load_list (dec_list),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .head      (head),
    .head_last (last),
    .ready     (ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ClearSt;
    end else if (accept) begin
      st <= st_next;
    end
  end

  assign out_byte = head.out_byte;
  assign byte_valid = head.byte_valid;
  assign string_done = head.string_done;
  assign error_code = head.error_code;

endmodule

/* rtl/jsu_decode.sv */
// Per-word decode: next parser state and the list of result words for one text byte.
`timescale 1ns / 1ps

module jsu_decode (
  input  jsu_pkg::st_t                     st,
  input  logic [7:0]                       ch,
  input  logic                             end_flag,
  output jsu_pkg::st_t                     st_next,
  output logic [2:0]                       res_n,
  output jsu_pkg::res_t [jsu_pkg::ResMax-1:0] res_list
);
  import jsu_pkg::*;

  function automatic logic [4:0] hex_dig(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [8:0] esc_map(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      ChQuote:  r = {1'b1, ChQuote};
      ChBslash: r = {1'b1, ChBslash};
      ChSlash:  r = {1'b1, ChSlash};
      ChB:      r = {1'b1, ChBs};
      ChF:      r = {1'b1, ChFf};
      ChN:      r = {1'b1, ChLf};
      ChR:      r = {1'b1, ChCr};
      ChT:      r = {1'b1, ChTab};
      default:  r = '0;
    endcase
    return r;
  endfunction

  logic [4:0]  hx;
  logic [15:0] acc_new;
  logic [2:0]  cnt_new;
  logic        is_hi;
  logic        is_lo;
  logic [20:0] enc_cp;
  enc_t        enc;
  enc_t        hi_enc;
  logic [8:0]  em;
  logic        pre;
  logic [2:0]  main_n;
  res_t [3:0]  main;
  res_t [3:0]  enc_res;
  res_t [2:0]  hi_res;

  assign hx = hex_dig(ch);
  assign em = esc_map(ch);
  assign acc_new = {st.acc, hx[3:0]};
  assign cnt_new = st.cnt + 3'd1;
  assign is_hi = (acc_new >= SurHiMin) && (acc_new <= SurHiMax);
  assign is_lo = (acc_new >= SurLoMin) && (acc_new <= SurLoMax);
  assign enc_cp = (st.mode == M_LOW_HEX && is_lo) ? PairBase + {1'b0, st.pend, acc_new[9:0]}
                                                  : {5'b0, acc_new};
  assign enc = utf8_enc(enc_cp);
  assign hi_enc = utf8_enc({5'b0, SurHiMin[15:10], st.pend});

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      enc_res[i] = byte_res(enc.b[i]);
    end
    for (int i = 0; i < 3; i++) begin
      hi_res[i] = byte_res(hi_enc.b[i]);
    end
  end

  always_comb begin
    st_next = st;
    pre = 1'b0;
    main_n = 3'd0;
    main = '0;
    if (end_flag) begin
      st_next = ClearSt;
      main_n = 3'd1;
      unique case (st.mode)
        M_BODY:     main[0] = err_res(ErrUnterm);
        M_ESC:      main[0] = err_res(ErrEndEsc);
        M_HEX:      main[0] = err_res(ErrShortU);
        M_HIGH: begin
          pre = 1'b1;
          main[0] = err_res(ErrUnterm);
        end
        M_HIGH_ESC: begin
          pre = 1'b1;
          main[0] = err_res(ErrEndEsc);
        end
        M_LOW_HEX: begin
          pre = 1'b1;
          main[0] = err_res(ErrShortU);
        end
        default:    main[0] = err_res(ErrStart);
      endcase
    end else begin
      unique case (st.mode)
        M_BODY, M_HIGH: begin
          if (st.mode == M_HIGH && ch == ChBslash) begin
            st_next.mode = M_HIGH_ESC;
          end else begin
            pre = (st.mode == M_HIGH);
            st_next.pend = '0;
            if (ch == ChQuote) begin
              main_n = 3'd1;
              main[0] = done_res();
              st_next = ClearSt;
            end else if (ch == ChBslash) begin
              st_next.mode = M_ESC;
            end else begin
              main_n = 3'd1;
              main[0] = byte_res(ch);
              st_next.mode = M_BODY;
            end
          end
        end
        M_ESC, M_HIGH_ESC: begin
          if (st.mode == M_HIGH_ESC && ch == ChU) begin
            st_next.mode = M_LOW_HEX;
            st_next.acc = '0;
            st_next.cnt = '0;
          end else begin
            pre = (st.mode == M_HIGH_ESC);
            st_next.pend = '0;
            if (em[8]) begin
              main_n = 3'd1;
              main[0] = byte_res(em[7:0]);
              st_next.mode = M_BODY;
            end else if (ch == ChU) begin
              st_next.mode = M_HEX;
              st_next.acc = '0;
              st_next.cnt = '0;
            end else begin
              main_n = 3'd1;
              main[0] = err_res(ErrEscape);
              st_next = ClearSt;
            end
          end
        end
        M_HEX, M_LOW_HEX: begin
          if (!hx[4]) begin
            main_n = 3'd1;
            main[0] = err_res(ErrHex);
            st_next = ClearSt;
          end else if (cnt_new < 3'd4) begin
            st_next.acc = acc_new[11:0];
            st_next.cnt = cnt_new;
          end else begin
            st_next.acc = '0;
            st_next.cnt = '0;
            st_next.pend = '0;
            if (st.mode == M_LOW_HEX && is_lo) begin
              main = enc_res;
              main_n = enc.n;
              st_next.mode = M_BODY;
            end else begin
              pre = (st.mode == M_LOW_HEX);
              if (is_hi) begin
                st_next.pend = acc_new[9:0];
                st_next.mode = M_HIGH;
              end else begin
                main = enc_res;
                main_n = enc.n;
                st_next.mode = M_BODY;
              end
            end
          end
        end
        default: begin
          if (ch == ChQuote) begin
            st_next = ClearSt;
            st_next.mode = M_BODY;
          end else if (ch == ChSp || ch == ChTab || ch == ChCr || ch == ChLf) begin
            st_next.mode = M_WAIT;
          end else begin
            main_n = 3'd1;
            main[0] = err_res(ErrStart);
            st_next = ClearSt;
          end
        end
      endcase
    end
  end

  // a flushed high surrogate always leads the list as three bytes
  assign res_n = pre ? main_n + 3'd3 : main_n;
  assign res_list = pre ? {main[2:0], hi_res} : {ZeroRes, ZeroRes, main};

endmodule

/* rtl/jsu_outq.sv */
// Result register: holds the result words of one text byte and shifts them out in order.
`timescale 1ns / 1ps

module jsu_outq (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  logic [2:0]                       load_n,
  input  jsu_pkg::res_t [jsu_pkg::ResMax-1:0] load_list,
  input  logic                             res_stall,
  output logic                             res_valid,
  output jsu_pkg::res_t                    head,
  output logic                             head_last,
  output logic                             ready
);
  import jsu_pkg::*;

  res_t [ResMax-1:0] list;
  logic [2:0]        rem;
  logic              take;

  assign res_valid = (rem != 3'd0);
  assign take = res_valid && !res_stall;
  assign head = list[0];
  assign head_last = (rem == 3'd1);
  assign ready = (rem == 3'd0) || (take && rem == 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= load_n;
    end else if (take) begin
      rem <= rem - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      list <= load_list;
    end else if (take) begin
      for (int i = 0; i < ResMax - 1; i++) begin
        list[i] <= list[i+1];
      end
      list[ResMax-1] <= ZeroRes;
    end
  end

endmodule

/* tb/jsu_sb_pkg.sv */
// Scoreboard class: predicts the unescaper's result words and checks them in order.
`timescale 1ns / 1ps

package jsu_sb_pkg;
  import jsu_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [2:0] error_code;
    logic       last;
  } res_word_t;

  class unescape_scoreboard;
    mode_t       mode;
    logic [15:0] code_accum;
    logic [15:0] pending_high;
    logic [2:0]  hex_count;
    res_word_t   word_q[$];
    res_word_t   expected_q[$];
    int          errors;

    function new();
      errors = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      mode = M_WAIT;
      code_accum = '0;
      pending_high = '0;
      hex_count = '0;
    endfunction

    function void emit(logic [7:0] b, logic valid, logic done, logic [2:0] err);
      res_word_t w;
      w = '{out_byte: b, byte_valid: valid, string_done: done, error_code: err, last: 1'b0};
      if (word_q.size() < ResMax) word_q.insert(word_q.size(), w);
    endfunction

    function void emit_byte(logic [7:0] b);
      emit(b, 1'b1, 1'b0, ErrNone);
    endfunction

    function void abort(logic [2:0] err);
      emit(8'h00, 1'b0, 1'b0, err);
      clear_parser();
    endfunction

    function void utf8_out(logic [20:0] cp);
      if (cp < Utf8Lim1) begin
        emit_byte(cp[7:0]);
      end else if (cp < Utf8Lim2) begin
        emit_byte(Lead2 | {3'b0, cp[10:6]});
        emit_byte(ContMark | {2'b0, cp[5:0]});
      end else if (cp < Utf8Lim3) begin
        emit_byte(Lead3 | {4'b0, cp[15:12]});
        emit_byte(ContMark | {2'b0, cp[11:6]});
        emit_byte(ContMark | {2'b0, cp[5:0]});
      end else begin
        emit_byte(Lead4 | {5'b0, cp[20:18]});
        emit_byte(ContMark | {2'b0, cp[17:12]});
        emit_byte(ContMark | {2'b0, cp[11:6]});
        emit_byte(ContMark | {2'b0, cp[5:0]});
      end
    endfunction

    function int digit_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
    endfunction

    function void take_body(logic [7:0] c);
      if (c == ChQuote) begin
        emit(8'h00, 1'b0, 1'b1, ErrNone);
        clear_parser();
      end else if (c == ChBslash) begin
        mode = M_ESC;
      end else begin
        emit_byte(c);
      end
    endfunction

    function void take_escape(logic [7:0] c);
      logic [7:0] v;
      case (c)
        ChQuote, ChBslash, ChSlash: v = c;
        ChB: v = ChBs;
        ChF: v = ChFf;
        ChN: v = ChLf;
        ChR: v = ChCr;
        ChT: v = ChTab;
        ChU: begin
          mode = M_HEX;
          code_accum = '0;
          hex_count = '0;
          return;
        end
        default: begin
          abort(ErrEscape);
          return;
        end
      endcase
      emit_byte(v);
      mode = M_BODY;
    endfunction

    // escape value with no high surrogate pending
    function void take_code(logic [15:0] cp);
      if (cp >= SurHiMin && cp <= SurHiMax) begin
        pending_high = cp;
        mode = M_HIGH;
      end else begin
        utf8_out({5'b0, cp});
        mode = M_BODY;
      end
      code_accum = '0;
      hex_count = '0;
    endfunction

    function void take_hex(logic [7:0] c, bit second);
      int d;
      logic [20:0] cp;
      d = digit_value(c);
      if (d < 0) begin
        abort(ErrHex);
        return;
      end
      code_accum = {code_accum[11:0], d[3:0]};
      hex_count = hex_count + 3'd1;
      if (hex_count < 3'd4) return;
      if (!second) begin
        take_code(code_accum);
      end else if (code_accum >= SurLoMin && code_accum <= SurLoMax) begin
        cp = PairBase + ({11'b0, pending_high[9:0]} << 10) + {11'b0, code_accum[9:0]};
        utf8_out(cp);
        pending_high = '0;
        code_accum = '0;
        hex_count = '0;
        mode = M_BODY;
      end else begin
        utf8_out({5'b0, pending_high});
        pending_high = '0;
        take_code(code_accum);
      end
    endfunction

    function void note_word(logic [7:0] c, logic at_end);
      word_q.delete();
      if (at_end) begin
        case (mode)
          M_BODY: abort(ErrUnterm);
          M_ESC: abort(ErrEndEsc);
          M_HEX: abort(ErrShortU);
          M_HIGH: begin
            utf8_out({5'b0, pending_high});
            abort(ErrUnterm);
          end
          M_HIGH_ESC: begin
            utf8_out({5'b0, pending_high});
            abort(ErrEndEsc);
          end
          M_LOW_HEX: begin
            utf8_out({5'b0, pending_high});
            abort(ErrShortU);
          end
          default: abort(ErrStart);
        endcase
      end else begin
        case (mode)
          M_BODY: take_body(c);
          M_ESC: take_escape(c);
          M_HEX: take_hex(c, 1'b0);
          M_HIGH: begin
            if (c == ChBslash) begin
              mode = M_HIGH_ESC;
            end else begin
              utf8_out({5'b0, pending_high});
              pending_high = '0;
              mode = M_BODY;
              take_body(c);
            end
          end
          M_HIGH_ESC: begin
            if (c == ChU) begin
              mode = M_LOW_HEX;
              code_accum = '0;
              hex_count = '0;
            end else begin
              utf8_out({5'b0, pending_high});
              pending_high = '0;
              mode = M_ESC;
              take_escape(c);
            end
          end
          M_LOW_HEX: take_hex(c, 1'b1);
          default: begin
            if (c == ChQuote) begin
              clear_parser();
              mode = M_BODY;
            end else if (!(c inside {ChSp, ChTab, ChCr, ChLf})) begin
              abort(ErrStart);
            end else begin
              mode = M_WAIT;
            end
          end
        endcase
      end
      if (word_q.size() > 0) word_q[word_q.size() - 1].last = 1'b1;
      foreach (word_q[i]) expected_q.insert(expected_q.size(), word_q[i]);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_word_t got);
      res_word_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %0h/%0b/%0b/%0d/%0b", $time,
                 got.out_byte, got.byte_valid, got.string_done, got.error_code, got.last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare("out_byte", want.out_byte, got.out_byte);
      compare("byte_valid", want.byte_valid, got.byte_valid);
      compare("string_done", want.string_done, got.string_done);
      compare("error_code", want.error_code, got.error_code);
      compare("last", want.last, got.last);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit all_results_seen();
      if (expected_q.size() != 0)
        $display("%0t: %0d expected words never arrived, expected %0h, actual none", $time,
                 expected_q.size(), expected_q[0].out_byte);
      return expected_q.size() == 0;
    endfunction
  endclass

endpackage

/* tb/tb.sv */
// Testbench top: drives text words, stalls results at random and checks every result word.
`timescale 1ns / 1ps

module tb;
  import jsu_pkg::*;
  import jsu_sb_pkg::*;

  localparam int WatchLimit = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       text_valid = 1'b0;
  logic [7:0] ch = 8'h00;
  logic       end_flag = 1'b0;
  logic       res_stall = 1'b0;
  logic       text_stall;
  logic       res_valid;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;
  logic [2:0] error_code;
  logic       last;

  typedef struct {
    logic [7:0] c;
    logic       e;
  } text_word_t;

  text_word_t         stim_q[$];
  unescape_scoreboard sb;
  bit                 calm = 1'b0;
  int                 quiet_cycles = 0;
  int                 esc_idx = 0;
  int                 brk_idx = 0;
  int                 str_idx = 0;
  logic [7:0]         blank_set[4] = '{ChSp, ChTab, ChCr, ChLf};
  logic [7:0]         esc_set[8] = '{ChQuote, ChBslash, ChSlash, ChB, ChF, ChN, ChR, ChT};

  always #6 clk = ~clk;

  json_string_unescape_utf8 dut (
    .clk(clk),
    .rst(rst),
    .text_valid(text_valid),
    .text_stall(text_stall),
    .ch(ch),
    .end_flag(end_flag),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .out_byte(out_byte),
    .byte_valid(byte_valid),
    .string_done(string_done),
    .error_code(error_code),
    .last(last)
  );

  function automatic void add_ch(logic [7:0] c);
    stim_q.insert(stim_q.size(), text_word_t'{c, 1'b0});
  endfunction

  function automatic void add_end();
    stim_q.insert(stim_q.size(), text_word_t'{8'($urandom), 1'b1});
  endfunction

  function automatic void add_text(string s);
    foreach (s[i]) add_ch(s[i]);
  endfunction

  function automatic void add_hex(logic [3:0] v);
    if (v < 4'd10) add_ch(8'("0") + 8'(v));
    else add_ch(($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(v) - 8'd10);
  endfunction

  function automatic void add_u(logic [15:0] cp);
    add_ch(ChBslash);
    add_ch(ChU);
    for (int i = 3; i >= 0; i--) add_hex(cp[4 * i +: 4]);
  endfunction

  // backslash-u with fewer than four digits
  function automatic void add_partial_u();
    add_ch(ChBslash);
    add_ch(ChU);
    repeat ($urandom_range(0, 3)) add_hex(4'($urandom));
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom); while (c == ChQuote || c == ChBslash);
    return c;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    do c = 8'($urandom); while (c inside {["0" : "9"], ["a" : "f"], ["A" : "F"]});
    return c;
  endfunction

  function automatic logic [15:0] pick_cp(int kind);
    case (kind)
      0: return 16'($urandom_range(0, 16'h7F));
      1: return 16'($urandom_range(16'h80, 16'h7FF));
      2: return 16'($urandom_range(16'h800, 16'hFFFF));
      3: return 16'($urandom_range(SurHiMin, SurHiMax));
      default: return 16'($urandom_range(SurLoMin, SurLoMax));
    endcase
  endfunction

  function automatic void add_string();
    logic [7:0] c;
    repeat ($urandom_range(0, 2)) add_ch(blank_set[$urandom_range(0, 3)]);
    add_ch(ChQuote);
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 5))
        0, 1: add_ch(plain_byte());
        2: begin
          add_ch(ChBslash);
          add_ch(esc_set[esc_idx % 8]);
          esc_idx++;
        end
        3: add_u(pick_cp($urandom_range(0, 4)));
        4: begin
          add_u(pick_cp(3));
          add_u(pick_cp(4));
        end
        default: begin
          // high surrogate not followed by a low one
          add_u(pick_cp(3));
          case ($urandom_range(0, 2))
            0: add_ch(plain_byte());
            1: begin
              add_ch(ChBslash);
              add_ch(esc_set[$urandom_range(0, 7)]);
            end
            default: add_u(pick_cp($urandom_range(0, 3)));
          endcase
        end
      endcase
    end
    if (str_idx % 2 == 0) begin
      add_ch(ChQuote);
    end else begin
      case (brk_idx % 9)
        0: add_end();
        1: begin
          add_ch(ChBslash);
          add_end();
        end
        2: begin
          add_ch(ChBslash);
          do c = 8'($urandom); while (c inside {esc_set, ChU});
          add_ch(c);
        end
        3: begin
          add_partial_u();
          add_ch(non_hex());
        end
        4: begin
          add_partial_u();
          add_end();
        end
        5: begin
          add_u(pick_cp(3));
          add_end();
        end
        6: begin
          add_u(pick_cp(3));
          add_ch(ChBslash);
          add_end();
        end
        7: begin
          add_u(pick_cp(3));
          add_partial_u();
          add_end();
        end
        default: begin
          add_u(pick_cp(3));
          add_partial_u();
          add_ch(non_hex());
        end
      endcase
      brk_idx++;
    end
    str_idx++;
    if ($urandom_range(0, 5) == 0) add_end();
  endfunction

  task automatic send_word(input text_word_t w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      text_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    text_valid <= 1'b1;
    ch <= w.c;
    end_flag <= w.e;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    sb.note_word(w.c, w.e);
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall)
      sb.check_result({out_byte, byte_valid, string_done, error_code, last});
  end

  always @(posedge clk) begin
    if (rst || (text_valid && !text_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    @(negedge rst);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      res_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    int base;
    bit drained;
    sb = new();
    add_text(" \t\r\n\"");
    add_ch(8'h00);
    add_ch(8'hFF);
    add_text("\\ud83D\\uDE00\"");
    add_end();
    add_text("x");
    base = stim_q.size();
    while (stim_q.size() < base + 200) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) add_end();
        else add_ch(8'($urandom));
      end else begin
        add_string();
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (stim_q[i]) begin
      calm = (i >= stim_q.size() - 30);
      send_word(stim_q[i]);
    end
    text_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    drained = sb.all_results_seen();
    if (sb.errors == 0 && drained) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/jsu_outq.sv
rtl/json_string_unescape_utf8.sv
tb/jsu_sb_pkg.sv
tb/tb.sv
